>>> design/agfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agfs_pkg
// Shared types, widths and codes of the audio gain and fade scaler.
// ----------------------------------------------------------------------------
package agfs_pkg;

    // default frame and channel limits
    localparam int MAX_FRAME_DEF = 4096;
    localparam int MAX_CH_DEF    = 8;

    // field and register widths
    localparam int SAMPLE_W   = 32;
    localparam int FRAME_W    = 13;
    localparam int FMT_W      = 2;
    localparam int GAIN_CFG_W = 15;
    localparam int CH_CFG_W   = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    // fade arithmetic widths
    localparam int STEP_W = 48;   // signed ramp step
    localparam int QUO_W  = 46;   // magnitude of the shifted gain difference
    localparam int GAIN_W = 41;   // signed working gain, saturated

    // ramp scale and rounding constants
    localparam int SHIFT_NARROW = 15;
    localparam int SHIFT_WIDE   = 31;
    localparam int ROUND_HALF   = 128;
    localparam int U8_OFFSET    = 128;

    // sample format codes
    localparam logic [FMT_W-1:0] FMT_U8  = 2'd0;
    localparam logic [FMT_W-1:0] FMT_S16 = 2'd1;
    localparam logic [FMT_W-1:0] FMT_S32 = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FORMAT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 2'd2;

    // register reset values
    localparam logic [FMT_W-1:0]      RST_FORMAT   = FMT_S16;
    localparam logic [GAIN_CFG_W-1:0] RST_GAIN     = 15'd256;
    localparam logic [CH_CFG_W-1:0]   RST_CHANNELS = 4'd2;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_in;
        logic [FRAME_W-1:0]         frame_samples;
    } t_in_word;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       frame_end;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_GAIN,
        ST_MUL,
        ST_SUM
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic div_start;
        logic gain;
        logic mul;
        logic commit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_div;
        logic div_done;
    } t_stat;

endpackage

>>> design/agfs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agfs_div
// Restoring divider, one quotient bit per cycle, for the fade step.
// ----------------------------------------------------------------------------
module agfs_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [agfs_pkg::QUO_W-1:0]   i_dividend,
    input  logic [agfs_pkg::FRAME_W-1:0] i_divisor,
    output logic                         o_done,
    output logic [agfs_pkg::QUO_W-1:0]   o_quotient
);
    import agfs_pkg::*;

    localparam int CNT_W = $clog2(QUO_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUO_W - 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [QUO_W-1:0] r_q;
    logic [FRAME_W-1:0] r_rem;
    logic [FRAME_W-1:0] r_d;

    logic [FRAME_W:0]   trial;
    logic               fits;
    logic [FRAME_W:0]   diff;
    logic [FRAME_W-1:0] n_rem;

    // trial subtract of the divisor from the shifted remainder
    always_comb begin
        trial = {r_rem, r_q[QUO_W-1]};
        fits  = trial >= {1'b0, r_d};
        diff  = trial - {1'b0, r_d};
        n_rem = fits ? diff[FRAME_W-1:0] : trial[FRAME_W-1:0];
    end

    // iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // quotient and remainder shift
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_d   <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[QUO_W-2:0], fits};
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without a running division");

endmodule

>>> design/agfs_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agfs_dp
// Datapath: registers, frame tracking, fade step, gain, multiply and clip.
// ----------------------------------------------------------------------------
module agfs_dp #(
    parameter int MAX_FRAME    = agfs_pkg::MAX_FRAME_DEF,
    parameter int MAX_CHANNELS = agfs_pkg::MAX_CH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [agfs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [agfs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  agfs_pkg::t_in_word              i_in_data,
    input  agfs_pkg::t_cmd                  i_cmd,
    output agfs_pkg::t_stat                 o_stat,
    output agfs_pkg::t_out_word             o_out_data
);
    import agfs_pkg::*;

    localparam int IDX_W  = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;
    localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int ACC_W  = STEP_W + IDX_W;
    localparam int LO_W   = 16;
    localparam int PLO_W  = SAMPLE_W + LO_W + 1;
    localparam int PHI_W  = SAMPLE_W + GAIN_W - LO_W;
    localparam int PROD_W = PHI_W + LO_W;
    localparam int Y_W    = PROD_W - 8 + 1;

    localparam logic signed [Y_W-1:0] U8_LO  = Y_W'(0);
    localparam logic signed [Y_W-1:0] U8_HI  = Y_W'(255);
    localparam logic signed [Y_W-1:0] S16_LO = Y_W'(-32768);
    localparam logic signed [Y_W-1:0] S16_HI = Y_W'(32767);
    localparam logic signed [Y_W-1:0] S32_LO = Y_W'(-64'sd2147483648);
    localparam logic signed [Y_W-1:0] S32_HI = Y_W'(64'sd2147483647);

    // configuration registers
    logic [FMT_W-1:0]      r_fmt;
    logic [GAIN_CFG_W-1:0] r_target;
    logic [CH_CFG_W-1:0]   r_channels;

    // frame state
    logic [GAIN_CFG_W-1:0]    r_prev;
    logic                     r_known;
    logic [IDX_W-1:0]         r_sidx;
    logic [CH_W-1:0]          r_cidx;
    logic signed [STEP_W-1:0] r_step;
    logic                     r_fading;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_neg;

    // item pipeline
    logic signed [SAMPLE_W-1:0] r_x;
    logic                       r_last;
    logic signed [GAIN_W-1:0]   r_gain;
    logic                       r_round;
    logic signed [PLO_W-1:0]    r_plo;
    logic signed [PHI_W-1:0]    r_phi;
    t_out_word                  r_out;

    logic [FMT_W-1:0]           fmt_eff;
    logic signed [SAMPLE_W-1:0] x_dec;
    logic [FRAME_W-1:0]         n_eff;
    logic [31:0]                ch_eff;
    logic                       frame_start;
    logic [GAIN_CFG_W-1:0]      prev_eff;
    logic                       fade_new;
    logic [GAIN_CFG_W-1:0]      abs_diff;
    logic [QUO_W-1:0]           dividend;
    logic                       cidx_wrap;
    logic                       last;
    logic                       div_done;
    logic [QUO_W-1:0]           quotient;
    logic signed [STEP_W-1:0]   step_mag;

    logic signed [ACC_W-1:0]    acc_sh;
    logic signed [ACC_W:0]      g_full;
    logic                       g_fits;
    logic signed [GAIN_W-1:0]   g_sat;
    logic signed [GAIN_W-1:0]   gain_sel;

    logic signed [PROD_W-1:0]   prod;
    logic signed [Y_W-1:0]      y_raw;
    logic signed [Y_W-1:0]      y_lo;
    logic signed [Y_W-1:0]      y_hi;
    logic signed [Y_W-1:0]      y_clip;

    // register writes, unknown indexes dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt      <= RST_FORMAT;
            r_target   <= RST_GAIN;
            r_channels <= RST_CHANNELS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_FORMAT:   r_fmt      <= i_cfg_data[FMT_W-1:0];
                REG_GAIN:     r_target   <= i_cfg_data[GAIN_CFG_W-1:0];
                REG_CHANNELS: r_channels <= i_cfg_data[CH_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // format, sample decode and frame geometry
    always_comb begin
        fmt_eff = (r_fmt == FMT_U8 || r_fmt == FMT_S16) ? r_fmt : FMT_S32;
        unique case (fmt_eff)
            FMT_U8:  x_dec = $signed({24'd0, i_in_data.sample_in[7:0]})
                             - SAMPLE_W'(U8_OFFSET);
            FMT_S16: x_dec = {{16{i_in_data.sample_in[15]}},
                              i_in_data.sample_in[15:0]};
            default: x_dec = i_in_data.sample_in;
        endcase

        if (i_in_data.frame_samples == '0)
            n_eff = FRAME_W'(1);
        else if (32'(i_in_data.frame_samples) > 32'(MAX_FRAME))
            n_eff = FRAME_W'(MAX_FRAME);
        else
            n_eff = i_in_data.frame_samples;

        if (r_channels == '0)
            ch_eff = 32'd1;
        else if (32'(r_channels) > 32'(MAX_CHANNELS))
            ch_eff = 32'(MAX_CHANNELS);
        else
            ch_eff = 32'(r_channels);

        frame_start = (r_sidx == '0) && (r_cidx == '0);
        prev_eff    = r_known ? r_prev : r_target;
        fade_new    = r_target != prev_eff;
        abs_diff    = (r_target >= prev_eff) ? (r_target - prev_eff)
                                             : (prev_eff - r_target);
        dividend    = (fmt_eff == FMT_S32) ? (QUO_W'(abs_diff) << SHIFT_WIDE)
                                           : (QUO_W'(abs_diff) << SHIFT_NARROW);
        cidx_wrap   = (32'(r_cidx) + 32'd1) >= ch_eff;
        last        = ((32'(r_sidx) + 32'd1) >= 32'(n_eff)) && cidx_wrap;
        step_mag    = $signed({{(STEP_W-QUO_W){1'b0}}, quotient});
    end

    // fade step division, started at the head of a fading frame
    agfs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dividend),
        .i_divisor  (n_eff),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    assign o_stat.need_div = frame_start && fade_new;
    assign o_stat.div_done = div_done;

    // frame state: start of frame, step latch, counters at commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev   <= '0;
            r_known  <= 1'b0;
            r_sidx   <= '0;
            r_cidx   <= '0;
            r_step   <= '0;
            r_fading <= 1'b0;
            r_acc    <= '0;
            r_neg    <= 1'b0;
        end else begin
            if (i_cmd.load && frame_start) begin
                r_prev   <= prev_eff;
                r_fading <= fade_new;
                r_neg    <= r_target < prev_eff;
                if (!fade_new)
                    r_step <= '0;
            end
            if (div_done)
                r_step <= r_neg ? -step_mag : step_mag;
            if (i_cmd.commit) begin
                if (r_last) begin
                    r_prev  <= r_target;
                    r_known <= 1'b1;
                    r_sidx  <= '0;
                    r_cidx  <= '0;
                    r_acc   <= '0;
                end else if (cidx_wrap) begin
                    r_cidx <= '0;
                    r_sidx <= r_sidx + 1'b1;
                    r_acc  <= r_acc + ACC_W'(r_step);
                end else begin
                    r_cidx <= r_cidx + 1'b1;
                end
            end
        end
    end

    // gain of this sample: ramp or steady target
    always_comb begin
        acc_sh   = (fmt_eff == FMT_S32) ? (r_acc >>> SHIFT_WIDE)
                                        : (r_acc >>> SHIFT_NARROW);
        g_full   = (ACC_W+1)'(acc_sh)
                 + $signed({{(ACC_W+1-GAIN_CFG_W){1'b0}}, r_prev});
        g_fits   = (&g_full[ACC_W:GAIN_W-1]) || !(|g_full[ACC_W:GAIN_W-1]);
        if (g_fits)
            g_sat = g_full[GAIN_W-1:0];
        else if (g_full[ACC_W])
            g_sat = {1'b1, {(GAIN_W-1){1'b0}}};
        else
            g_sat = {1'b0, {(GAIN_W-1){1'b1}}};
        gain_sel = r_fading ? g_sat : $signed({{(GAIN_W-GAIN_CFG_W){1'b0}}, r_target});
    end

    // product, rounding, shift and clip
    always_comb begin
        prod  = (PROD_W'(r_phi) <<< LO_W) + PROD_W'(r_plo)
              + (r_round ? PROD_W'(ROUND_HALF) : PROD_W'(0));
        y_raw = $signed({prod[PROD_W-1], prod[PROD_W-1:8]})
              + ((fmt_eff == FMT_U8) ? Y_W'(U8_OFFSET) : Y_W'(0));
        unique case (fmt_eff)
            FMT_U8: begin
                y_lo = U8_LO;
                y_hi = U8_HI;
            end
            FMT_S16: begin
                y_lo = S16_LO;
                y_hi = S16_HI;
            end
            default: begin
                y_lo = S32_LO;
                y_hi = S32_HI;
            end
        endcase
        if (y_raw < y_lo)
            y_clip = y_lo;
        else if (y_raw > y_hi)
            y_clip = y_hi;
        else
            y_clip = y_raw;
    end

    // item pipeline registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x    <= x_dec;
            r_last <= last;
        end
        if (i_cmd.gain) begin
            r_gain  <= gain_sel;
            r_round <= !r_fading;
        end
        if (i_cmd.mul) begin
            r_plo <= r_x * $signed({1'b0, r_gain[LO_W-1:0]});
            r_phi <= r_x * $signed(r_gain[GAIN_W-1:LO_W]);
        end
        if (i_cmd.commit) begin
            r_out.sample_out <= y_clip[SAMPLE_W-1:0];
            r_out.frame_end  <= r_last;
        end
    end

    assign o_out_data = r_out;

    a_first_frame_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_known |-> !r_fading)
        else $error("fade before any frame has ended");

    a_steady_step_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_fading |-> (r_step == '0))
        else $error("ramp step left over in a steady frame");

    a_frame_head_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_sidx == '0) && (r_cidx == '0)) |-> (r_acc == '0))
        else $error("ramp accumulator not cleared at frame head");

endmodule

>>> design/agfs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agfs_ctrl
// Controller: handshakes, sequencing of division, gain, multiply and commit.
// ----------------------------------------------------------------------------
module agfs_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  agfs_pkg::t_stat i_stat,
    output agfs_pkg::t_cmd  o_cmd
);
    import agfs_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    // state and output word flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and commands
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_stat.need_div) begin
                        o_cmd.div_start = 1'b1;
                        n_state         = ST_DIV;
                    end else begin
                        n_state = ST_GAIN;
                    end
                end
            end
            ST_DIV: begin
                if (i_stat.div_done)
                    n_state = ST_GAIN;
            end
            ST_GAIN: begin
                o_cmd.gain = 1'b1;
                n_state    = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_SUM;
            end
            ST_SUM: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;

    a_word_from_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_SUM))
        else $error("output word raised outside the final step");

    a_commit_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SUM && r_out_valid && !i_out_ready) |=> (r_state == ST_SUM))
        else $error("result left the final step over a waiting word");

endmodule

>>> design/audio_gain_fade_scaler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_gain_fade_scaler_top
// Q8 gain with saturation on interleaved u8/s16/s32 samples, with a linear
// gain ramp over a frame whenever the target gain moved since the last frame.
//
//   channel   direction  signals                          word
//   in        input      i_in_valid / o_in_ready          t_in_word
//   out       output     o_out_valid / i_out_ready        t_out_word
//   cfg       input      i_cfg_we, i_cfg_index, i_cfg_data  write only
//
// a sample steps through accept, gain select, split multiply, then sum and clip
// the first sample of a fading frame also waits for the serial step divider
// the output register lets the next sample be accepted while a word waits
// a stalled output holds the sequencer in its final step until the slot frees
// reset is synchronous, active low; no clearing pass is needed
// ----------------------------------------------------------------------------
module audio_gain_fade_scaler_top #(
    parameter int MAX_FRAME    = agfs_pkg::MAX_FRAME_DEF,
    parameter int MAX_CHANNELS = agfs_pkg::MAX_CH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  agfs_pkg::t_in_word              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output agfs_pkg::t_out_word             o_out_data,
    input  logic                            i_cfg_we,
    input  logic [agfs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [agfs_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import agfs_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // sequencer
    agfs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // arithmetic and state
    agfs_dp #(
        .MAX_FRAME    (MAX_FRAME),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_data  (o_out_data)
    );

endmodule
